// File: sv/csg_pkg.sv
// Shared types, constants and arithmetic helpers for the channel scale unit.
package csg_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int FRAC_BITS    = DATA_WIDTH - 4;
  localparam int ACC_WIDTH    = 56;
  localparam int MAX_CHANNELS = 32;
  localparam int PROD_W       = 2 * DATA_WIDTH;
  localparam int SUM_W        = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 5;
  localparam int KIND_W    = 2;
  localparam int COUNT_W   = 16;
  localparam int CHCOUNT_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FORWARD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BACKWARD = 2'd2;

  localparam logic [KIND_W-1:0] KIND_SCALED     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INPUT_GRAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SCALE_GRAD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_OUTER_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROPAGATE_INPUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROPAGATE_SCALE = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0]             command;
    logic [IDX_W-1:0]             scale_index;
    logic signed [DATA_WIDTH-1:0] scale_value;
    logic signed [DATA_WIDTH-1:0] data_value;
    logic signed [DATA_WIDTH-1:0] grad_value;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]            kind;
    logic signed [DATA_WIDTH-1:0] value;
    logic signed [ACC_WIDTH-1:0]  scale_grad;
    logic [IDX_W-1:0]             channel;
    logic                         last;
  } out_item_t;

  localparam logic signed [PROD_W:0] HALF_LSB =
    {{(PROD_W+1-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [PROD_W:0] DATA_HI =
    {{(PROD_W+2-DATA_WIDTH){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [PROD_W:0] DATA_LO =
    {{(PROD_W+2-DATA_WIDTH){1'b1}}, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] ACC_HI =
    {{(SUM_W+1-ACC_WIDTH){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_LO =
    {{(SUM_W+1-ACC_WIDTH){1'b1}}, {(ACC_WIDTH-1){1'b0}}};

  // Round half up to Q3.12 and saturate to DATA_WIDTH bits.
  function automatic logic signed [DATA_WIDTH-1:0] round_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W:0] s;
    logic signed [PROD_W:0] q;
    s = (PROD_W+1)'(p) + HALF_LSB;
    q = s >>> FRAC_BITS;
    if (q > DATA_HI) begin
      return DATA_HI[DATA_WIDTH-1:0];
    end else if (q < DATA_LO) begin
      return DATA_LO[DATA_WIDTH-1:0];
    end
    return q[DATA_WIDTH-1:0];
  endfunction

  // Add a full product into an accumulator, saturating at ACC_WIDTH bits.
  function automatic logic signed [ACC_WIDTH-1:0] acc_sat_add(
    input logic signed [ACC_WIDTH-1:0] acc,
    input logic signed [PROD_W-1:0]    p
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(p);
    if (s > ACC_HI) begin
      return ACC_HI[ACC_WIDTH-1:0];
    end else if (s < ACC_LO) begin
      return ACC_LO[ACC_WIDTH-1:0];
    end
    return s[ACC_WIDTH-1:0];
  endfunction

endpackage

// File: sv/csg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/channel_scale_with_gradient_unit.sv
// Per-channel scale unit: forward scaling, input gradient and scale gradient accumulation.
//
// Items are taken one at a time. A load writes the scale memory, restarts the
// outer/channel/inner position counters and clears all accumulators at once through
// per-channel valid bits. A forward or backward element goes in steps: read the scale and
// accumulator memories, multiply, then round/saturate, write the accumulator back and
// present the result. With scale propagation on, the backward element that closes a full
// pass reads the accumulator memory out over its single read port, channel by channel,
// emitting one scale-gradient transaction per channel and clearing the accumulators at the
// end. A stalled output register holds the unit in place until the result is taken.
module channel_scale_with_gradient_unit #(
  parameter int MAX_CHANNELS = csg_pkg::MAX_CHANNELS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csg_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csg_pkg::out_item_t                  out_data,
  input  logic                                cfg_wr_en,
  input  logic [csg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [csg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DW   = csg_pkg::DATA_WIDTH;
  localparam int AW   = csg_pkg::ACC_WIDTH;
  localparam int PW   = csg_pkg::PROD_W;
  localparam int CW   = csg_pkg::COUNT_W;
  localparam int CCW  = csg_pkg::CHCOUNT_W;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_MUL       = 3'd1;
  localparam logic [2:0] S_RES       = 3'd2;
  localparam logic [2:0] S_SWEEP_RD  = 3'd3;
  localparam logic [2:0] S_SWEEP_OUT = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         outer_count_r, outer_count_nxt;
  logic [CCW-1:0]        channel_count_r, channel_count_nxt;
  logic [CW-1:0]         inner_count_r, inner_count_nxt;
  logic                  prop_in_r, prop_in_nxt;
  logic                  prop_sc_r, prop_sc_nxt;
  logic [CW-1:0]         inner_pos_r, inner_pos_nxt;
  logic [CH_W-1:0]       chan_pos_r, chan_pos_nxt;
  logic [CW-1:0]         outer_pos_r, outer_pos_nxt;
  logic [MAX_CHANNELS-1:0] vld_r, vld_nxt;
  logic                  fwd_r, fwd_nxt;
  logic [CH_W-1:0]       ch_r, ch_nxt;
  logic                  pass_end_r, pass_end_nxt;
  logic signed [DW-1:0]  data_r, data_nxt;
  logic signed [DW-1:0]  grad_r, grad_nxt;
  logic signed [PW-1:0]  prod_a_r, prod_a_nxt;
  logic signed [PW-1:0]  prod_g_r, prod_g_nxt;
  logic signed [AW-1:0]  acc_q_r, acc_q_nxt;
  logic [CH_W-1:0]       sweep_c_r, sweep_c_nxt;
  logic                  out_valid_r, out_valid_nxt;
  csg_pkg::out_item_t    out_data_r, out_data_nxt;

  logic [CW-1:0]         oc, ic;
  logic [CCW-1:0]        cc;
  logic [CH_W-1:0]       ch_now;
  logic                  inner_wrap, ch_wrap, outer_wrap;
  logic                  accept, slot_free, sweep_last;

  logic                  scale_we;
  logic [CH_W-1:0]       scale_waddr;
  logic                  acc_we;
  logic signed [AW-1:0]  acc_wdata;
  logic                  acc_re;
  logic [CH_W-1:0]       acc_raddr;
  logic [DW-1:0]         scale_rd;
  logic [AW-1:0]         acc_rd;
  logic signed [DW-1:0]  mul_op;

  csg_ram #(.WIDTH(DW), .DEPTH(MAX_CHANNELS)) u_scale_ram (
    .clk     (clk),
    .wr_en   (scale_we),
    .wr_addr (scale_waddr),
    .wr_data (in_data.scale_value),
    .rd_en   (accept),
    .rd_addr (ch_now),
    .rd_data (scale_rd)
  );

  csg_ram #(.WIDTH(AW), .DEPTH(MAX_CHANNELS)) u_acc_ram (
    .clk     (clk),
    .wr_en   (acc_we),
    .wr_addr (ch_r),
    .wr_data (acc_wdata),
    .rd_en   (acc_re),
    .rd_addr (acc_raddr),
    .rd_data (acc_rd)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  assign oc = (outer_count_r == '0) ? CW'(1) : outer_count_r;
  assign ic = (inner_count_r == '0) ? CW'(1) : inner_count_r;
  assign cc = (channel_count_r == '0) ? CCW'(1) :
              ((7'(channel_count_r) > 7'(MAX_CHANNELS)) ? CCW'(MAX_CHANNELS) : channel_count_r);

  assign ch_now     = (7'(chan_pos_r) < 7'(cc)) ? chan_pos_r : CH_W'(cc - CCW'(1));
  assign inner_wrap = (17'(inner_pos_r) + 17'd1) >= 17'(ic);
  assign ch_wrap    = (7'(ch_now) + 7'd1) >= 7'(cc);
  assign outer_wrap = (17'(outer_pos_r) + 17'd1) >= 17'(oc);
  assign sweep_last = (7'(sweep_c_r) + 7'd1) >= 7'(cc);

  assign scale_we    = accept && (in_data.command == csg_pkg::CMD_LOAD) &&
                       (7'(in_data.scale_index) < 7'(MAX_CHANNELS));
  assign scale_waddr = CH_W'(in_data.scale_index);
  assign acc_re      = accept || (state_r == S_SWEEP_RD);
  assign acc_raddr   = (state_r == S_SWEEP_RD) ? sweep_c_r : ch_now;
  assign acc_wdata   = csg_pkg::acc_sat_add(acc_q_r, prod_g_r);
  assign acc_we      = (state_r == S_RES) && !fwd_r && prop_sc_r && (!prop_in_r || slot_free);
  assign mul_op      = fwd_r ? data_r : grad_r;

  always_comb begin
    state_nxt         = state_r;
    outer_count_nxt   = outer_count_r;
    channel_count_nxt = channel_count_r;
    inner_count_nxt   = inner_count_r;
    prop_in_nxt       = prop_in_r;
    prop_sc_nxt       = prop_sc_r;
    inner_pos_nxt     = inner_pos_r;
    chan_pos_nxt      = chan_pos_r;
    outer_pos_nxt     = outer_pos_r;
    vld_nxt           = vld_r;
    fwd_nxt           = fwd_r;
    ch_nxt            = ch_r;
    pass_end_nxt      = pass_end_r;
    data_nxt          = data_r;
    grad_nxt          = grad_r;
    prod_a_nxt        = prod_a_r;
    prod_g_nxt        = prod_g_r;
    acc_q_nxt         = acc_q_r;
    sweep_c_nxt       = sweep_c_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_data_nxt      = out_data_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        csg_pkg::CFG_OUTER_COUNT:     outer_count_nxt   = cfg_data;
        csg_pkg::CFG_CHANNEL_COUNT:   channel_count_nxt = cfg_data[CCW-1:0];
        csg_pkg::CFG_INNER_COUNT:     inner_count_nxt   = cfg_data;
        csg_pkg::CFG_PROPAGATE_INPUT: prop_in_nxt       = cfg_data[0];
        csg_pkg::CFG_PROPAGATE_SCALE: prop_sc_nxt       = cfg_data[0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.command)
            csg_pkg::CMD_LOAD: begin
              vld_nxt       = '0;
              inner_pos_nxt = '0;
              chan_pos_nxt  = '0;
              outer_pos_nxt = '0;
            end
            csg_pkg::CMD_FORWARD, csg_pkg::CMD_BACKWARD: begin
              fwd_nxt      = (in_data.command == csg_pkg::CMD_FORWARD);
              ch_nxt       = ch_now;
              pass_end_nxt = inner_wrap && ch_wrap && outer_wrap;
              data_nxt     = in_data.data_value;
              grad_nxt     = in_data.grad_value;
              if (inner_wrap) begin
                inner_pos_nxt = '0;
                if (ch_wrap) begin
                  chan_pos_nxt  = '0;
                  outer_pos_nxt = outer_wrap ? '0 : outer_pos_r + CW'(1);
                end else begin
                  chan_pos_nxt = ch_now + CH_W'(1);
                end
              end else begin
                inner_pos_nxt = inner_pos_r + CW'(1);
              end
              state_nxt = S_MUL;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        prod_a_nxt = PW'(mul_op * $signed(scale_rd));
        prod_g_nxt = PW'(grad_r * data_r);
        acc_q_nxt  = vld_r[ch_r] ? $signed(acc_rd) : '0;
        state_nxt  = S_RES;
      end
      S_RES: begin
        if (fwd_r) begin
          if (slot_free) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.kind        = csg_pkg::KIND_SCALED;
            out_data_nxt.value       = csg_pkg::round_sat(prod_a_r);
            out_data_nxt.scale_grad  = '0;
            out_data_nxt.channel     = csg_pkg::IDX_W'(ch_r);
            out_data_nxt.last        = 1'b1;
            state_nxt                = S_IDLE;
          end
        end else if (!prop_in_r || slot_free) begin
          if (prop_sc_r) begin
            vld_nxt[ch_r] = 1'b1;
          end
          if (prop_in_r) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.kind        = csg_pkg::KIND_INPUT_GRAD;
            out_data_nxt.value       = csg_pkg::round_sat(prod_a_r);
            out_data_nxt.scale_grad  = '0;
            out_data_nxt.channel     = csg_pkg::IDX_W'(ch_r);
            out_data_nxt.last        = !(pass_end_r && prop_sc_r);
          end
          sweep_c_nxt = '0;
          state_nxt   = (pass_end_r && prop_sc_r) ? S_SWEEP_RD : S_IDLE;
        end
      end
      S_SWEEP_RD: begin
        state_nxt = S_SWEEP_OUT;
      end
      S_SWEEP_OUT: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.kind        = csg_pkg::KIND_SCALE_GRAD;
          out_data_nxt.value       = '0;
          out_data_nxt.scale_grad  = vld_r[sweep_c_r] ? $signed(acc_rd) : '0;
          out_data_nxt.channel     = csg_pkg::IDX_W'(sweep_c_r);
          out_data_nxt.last        = sweep_last;
          if (sweep_last) begin
            vld_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            sweep_c_nxt = sweep_c_r + CH_W'(1);
            state_nxt   = S_SWEEP_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      outer_count_r   <= CW'(1);
      channel_count_r <= CCW'(1);
      inner_count_r   <= CW'(1);
      prop_in_r       <= 1'b1;
      prop_sc_r       <= 1'b1;
      inner_pos_r     <= '0;
      chan_pos_r      <= '0;
      outer_pos_r     <= '0;
      vld_r           <= '0;
      out_valid_r     <= 1'b0;
      fwd_r           <= 1'b0;
      ch_r            <= '0;
      pass_end_r      <= 1'b0;
      sweep_c_r       <= '0;
    end else begin
      state_r         <= state_nxt;
      outer_count_r   <= outer_count_nxt;
      channel_count_r <= channel_count_nxt;
      inner_count_r   <= inner_count_nxt;
      prop_in_r       <= prop_in_nxt;
      prop_sc_r       <= prop_sc_nxt;
      inner_pos_r     <= inner_pos_nxt;
      chan_pos_r      <= chan_pos_nxt;
      outer_pos_r     <= outer_pos_nxt;
      vld_r           <= vld_nxt;
      out_valid_r     <= out_valid_nxt;
      fwd_r           <= fwd_nxt;
      ch_r            <= ch_nxt;
      pass_end_r      <= pass_end_nxt;
      sweep_c_r       <= sweep_c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r     <= data_nxt;
    grad_r     <= grad_nxt;
    prod_a_r   <= prod_a_nxt;
    prod_g_r   <= prod_g_nxt;
    acc_q_r    <= acc_q_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP_RD || state_r == S_SWEEP_OUT) |-> (7'(sweep_c_r) < 7'(cc)))
    else $error("accumulator read-out index beyond channel count");

  a_load_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.command == csg_pkg::CMD_LOAD) |=> (vld_r == '0))
    else $error("accumulators not cleared after load");

  a_channel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_RES) |-> (7'(ch_r) < 7'(cc)))
    else $error("working channel beyond channel count");

  a_acc_write_backward: assert property (@(posedge clk) disable iff (!rst_n)
    acc_we |-> (!fwd_r && prop_sc_r && state_r == S_RES))
    else $error("accumulator written outside a backward element");

  a_sweep_ends_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP_OUT && slot_free && sweep_last) |=> (vld_r == '0 && state_r == S_IDLE))
    else $error("accumulators kept after scale gradient read-out");
`endif

endmodule

// File: tb/tb_channel_scale_with_gradient_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the channel scale unit: directed and random traffic.
module tb_channel_scale_with_gradient_unit;

  localparam logic [csg_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS = 30;
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned COUNT_CAP = 65535;
  localparam longint Q_HI = 32767;
  localparam longint Q_LO = -32768;
  localparam longint ACC_MAX = 64'sh007F_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam logic [csg_pkg::DATA_WIDTH-1:0] Q_MAX = 16'h7FFF;
  localparam logic [csg_pkg::DATA_WIDTH-1:0] Q_MIN = 16'h8000;
  localparam logic [csg_pkg::DATA_WIDTH-1:0] Q_ONE = 16'h1000;
  localparam logic [csg_pkg::DATA_WIDTH-1:0] Q_HALF = 16'h0800;

  typedef enum int {RDY_FREE, RDY_RANDOM, RDY_PATTERN} ready_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  csg_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  csg_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [csg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [csg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic signed [csg_pkg::DATA_WIDTH-1:0] scale_mem [csg_pkg::MAX_CHANNELS];
  longint grad_acc [csg_pkg::MAX_CHANNELS];
  int unsigned inner_pos, channel_pos, outer_pos;
  int unsigned outer_reg, channel_reg, inner_reg;
  bit prop_input_reg, prop_scale_reg;

  csg_pkg::out_item_t pending_results[$];
  csg_pkg::out_item_t got, want;
  int mismatches = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int ready_hold = 0;
  int ready_span = 0;
  ready_mode_t ready_mode = RDY_FREE;
  logic [15:0] ready_bits = 16'hFFFF;

  channel_scale_with_gradient_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic signed [csg_pkg::DATA_WIDTH-1:0] q12_product(
    input logic signed [csg_pkg::DATA_WIDTH-1:0] a,
    input logic signed [csg_pkg::DATA_WIDTH-1:0] b
  );
    longint q;
    q = (longint'(a) * longint'(b) + (longint'(1) <<< (csg_pkg::FRAC_BITS - 1)))
        >>> csg_pkg::FRAC_BITS;
    if (q > Q_HI) return Q_MAX;
    if (q < Q_LO) return Q_MIN;
    return q[csg_pkg::DATA_WIDTH-1:0];
  endfunction

  function automatic longint acc_saturating_add(input longint acc, input longint p);
    longint s;
    s = acc + p;
    if (s > ACC_MAX) return ACC_MAX;
    if (s < ACC_MIN) return ACC_MIN;
    return s;
  endfunction

  function automatic int unsigned effective_count(input int unsigned v,
                                                  input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic csg_pkg::in_item_t pack_item(
    input logic [csg_pkg::CMD_W-1:0] cmd,
    input logic [csg_pkg::IDX_W-1:0] idx,
    input logic [csg_pkg::DATA_WIDTH-1:0] sv,
    input logic [csg_pkg::DATA_WIDTH-1:0] dv,
    input logic [csg_pkg::DATA_WIDTH-1:0] gv
  );
    csg_pkg::in_item_t it;
    it.command = cmd;
    it.scale_index = idx;
    it.scale_value = sv;
    it.data_value = dv;
    it.grad_value = gv;
    return it;
  endfunction

  function automatic logic [csg_pkg::DATA_WIDTH-1:0] rand_q12();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return csg_pkg::DATA_WIDTH'($urandom_range(0, 16));
      3: return -csg_pkg::DATA_WIDTH'($urandom_range(1, 16));
      default: return csg_pkg::DATA_WIDTH'($urandom);
    endcase
  endfunction

  function automatic csg_pkg::in_item_t rand_element(input logic [csg_pkg::CMD_W-1:0] cmd);
    return pack_item(cmd, csg_pkg::IDX_W'($urandom), csg_pkg::DATA_WIDTH'($urandom),
                     rand_q12(), rand_q12());
  endfunction

  task automatic reset_model();
    foreach (scale_mem[c]) scale_mem[c] = '0;
    foreach (grad_acc[c]) grad_acc[c] = 0;
    inner_pos = 0;
    channel_pos = 0;
    outer_pos = 0;
    outer_reg = 1;
    channel_reg = 1;
    inner_reg = 1;
    prop_input_reg = 1'b1;
    prop_scale_reg = 1'b1;
  endtask

  task automatic channel_scale_step(input csg_pkg::in_item_t it);
    int unsigned oc, cc, ic, ch;
    bit pass_end;
    logic signed [csg_pkg::DATA_WIDTH-1:0] scale, data, grad;
    csg_pkg::out_item_t r;
    csg_pkg::out_item_t batch[$];
    oc = effective_count(outer_reg, COUNT_CAP);
    cc = effective_count(channel_reg, csg_pkg::MAX_CHANNELS);
    ic = effective_count(inner_reg, COUNT_CAP);
    if (it.command == csg_pkg::CMD_LOAD) begin
      scale_mem[it.scale_index] = it.scale_value;
      foreach (grad_acc[c]) grad_acc[c] = 0;
      inner_pos = 0;
      channel_pos = 0;
      outer_pos = 0;
      return;
    end
    if (it.command == CMD_UNUSED) return;

    ch = (channel_pos < cc) ? channel_pos : cc - 1;
    data = it.data_value;
    grad = it.grad_value;
    scale = scale_mem[ch];
    pass_end = (inner_pos + 1 >= ic) && (ch + 1 >= cc) && (outer_pos + 1 >= oc);
    if (inner_pos + 1 >= ic) begin
      inner_pos = 0;
      if (ch + 1 >= cc) begin
        channel_pos = 0;
        outer_pos = (outer_pos + 1 >= oc) ? 0 : outer_pos + 1;
      end else begin
        channel_pos = ch + 1;
      end
    end else begin
      inner_pos = inner_pos + 1;
    end

    if (it.command == csg_pkg::CMD_FORWARD) begin
      r = '0;
      r.kind = csg_pkg::KIND_SCALED;
      r.value = q12_product(data, scale);
      r.channel = ch[csg_pkg::IDX_W-1:0];
      r.last = 1'b1;
      pending_results.push_back(r);
      return;
    end

    if (prop_scale_reg)
      grad_acc[ch] = acc_saturating_add(grad_acc[ch], longint'(grad) * longint'(data));
    if (prop_input_reg) begin
      r = '0;
      r.kind = csg_pkg::KIND_INPUT_GRAD;
      r.value = q12_product(grad, scale);
      r.channel = ch[csg_pkg::IDX_W-1:0];
      batch.push_back(r);
    end
    if (pass_end && prop_scale_reg) begin
      for (int c = 0; c < cc; c++) begin
        r = '0;
        r.kind = csg_pkg::KIND_SCALE_GRAD;
        r.scale_grad = grad_acc[c][csg_pkg::ACC_WIDTH-1:0];
        r.channel = csg_pkg::IDX_W'(c);
        batch.push_back(r);
      end
      foreach (grad_acc[c]) grad_acc[c] = 0;
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) pending_results.push_back(batch[k]);
  endtask

  task automatic compare_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected transaction: expected none, actual kind %0d value %h",
                 $time, got.kind, got.value);
        $display("%0t:   grad %h ch %0d last %b", $time, got.scale_grad, got.channel,
                 got.last);
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", 64'(want.kind), 64'(got.kind));
        compare_field("value", 64'(want.value), 64'(got.value));
        compare_field("scale_grad", 64'(want.scale_grad), 64'(got.scale_grad));
        compare_field("channel", 64'(want.channel), 64'(got.channel));
        compare_field("last", 64'(want.last), 64'(got.last));
      end
    end
  end

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
      out_ready <= 1'b0;
    end else begin
      if (ready_span == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 2));
        ready_bits = 16'($urandom) | 16'h0001;
        ready_span = $urandom_range(8, 64);
      end
      ready_span = ready_span - 1;
      case (ready_mode)
        RDY_FREE: out_ready <= 1'b1;
        RDY_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_ready <= ready_bits[0];
          ready_bits = {ready_bits[0], ready_bits[15:1]};
        end
      endcase
    end
  end

  task automatic send_item(input csg_pkg::in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    channel_scale_step(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [csg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [csg_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      csg_pkg::CFG_OUTER_COUNT: outer_reg = 32'(val[csg_pkg::COUNT_W-1:0]);
      csg_pkg::CFG_CHANNEL_COUNT: channel_reg = 32'(val[csg_pkg::CHCOUNT_W-1:0]);
      csg_pkg::CFG_INNER_COUNT: inner_reg = 32'(val[csg_pkg::COUNT_W-1:0]);
      csg_pkg::CFG_PROPAGATE_INPUT: prop_input_reg = val[0];
      csg_pkg::CFG_PROPAGATE_SCALE: prop_scale_reg = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(input int unsigned oc, input int unsigned cc,
                           input int unsigned ic, input bit pin, input bit psc);
    wait_idle();
    write_reg(csg_pkg::CFG_OUTER_COUNT, csg_pkg::CFG_DATA_W'(oc));
    write_reg(csg_pkg::CFG_CHANNEL_COUNT, csg_pkg::CFG_DATA_W'(cc));
    write_reg(csg_pkg::CFG_INNER_COUNT, csg_pkg::CFG_DATA_W'(ic));
    write_reg(csg_pkg::CFG_PROPAGATE_INPUT, csg_pkg::CFG_DATA_W'(pin));
    write_reg(csg_pkg::CFG_PROPAGATE_SCALE, csg_pkg::CFG_DATA_W'(psc));
  endtask

  task automatic fill_scale_table();
    logic [csg_pkg::DATA_WIDTH-1:0] v;
    for (int c = 0; c < csg_pkg::MAX_CHANNELS; c++) begin
      case (c)
        0: v = Q_MAX;
        1: v = Q_MIN;
        2: v = Q_ONE;
        default: v = rand_q12();
      endcase
      send_item(pack_item(csg_pkg::CMD_LOAD, csg_pkg::IDX_W'(c), v,
                          csg_pkg::DATA_WIDTH'($urandom), csg_pkg::DATA_WIDTH'($urandom)));
    end
  endtask

  task automatic test_directed();
    send_item(pack_item(csg_pkg::CMD_LOAD, 0, Q_MAX, 0, 0));
    send_item(pack_item(csg_pkg::CMD_FORWARD, 0, 0, Q_MAX, 0));
    send_item(pack_item(csg_pkg::CMD_FORWARD, 0, 0, Q_MIN, 0));
    send_item(pack_item(csg_pkg::CMD_FORWARD, 0, 0, 0, 0));
    // half scale: ties round toward plus infinity
    send_item(pack_item(csg_pkg::CMD_LOAD, 0, Q_HALF, 0, 0));
    send_item(pack_item(csg_pkg::CMD_FORWARD, 0, 0, 16'h0001, 0));
    send_item(pack_item(csg_pkg::CMD_FORWARD, 0, 0, 16'hFFFF, 0));
    send_item(pack_item(csg_pkg::CMD_FORWARD, 0, 0, 16'h0003, 0));
    send_item(pack_item(csg_pkg::CMD_LOAD, 5'd31, Q_MIN, Q_MAX, Q_MAX));
    send_item(pack_item(csg_pkg::CMD_LOAD, 0, Q_MIN, 0, 0));
    send_item(pack_item(csg_pkg::CMD_FORWARD, 0, 0, Q_MIN, 0));
    send_item(pack_item(csg_pkg::CMD_BACKWARD, 0, 0, Q_MAX, Q_MIN));
    send_item(pack_item(csg_pkg::CMD_BACKWARD, 0, 0, Q_MIN, Q_MIN));
    send_item(pack_item(CMD_UNUSED, 5'd31, Q_MAX, Q_MAX, Q_MAX));
    send_item(pack_item(csg_pkg::CMD_BACKWARD, 0, 0, 0, Q_MAX));
    configure(1, 1, 1, 1'b0, 1'b0);
    send_item(pack_item(csg_pkg::CMD_BACKWARD, 0, 0, Q_MAX, Q_MAX));
    configure(1, 1, 1, 1'b0, 1'b1);
    send_item(pack_item(csg_pkg::CMD_BACKWARD, 0, 0, Q_MIN, Q_MAX));
    configure(1, 1, 1, 1'b1, 1'b0);
    send_item(pack_item(csg_pkg::CMD_BACKWARD, 0, 0, Q_MAX, Q_MIN));
  endtask

  task automatic test_pass_walk();
    configure(2, 3, 2, 1'b1, 1'b1);
    fill_scale_table();
    for (int k = 0; k < 12; k++)
      send_item(rand_element((k % 3 == 1) ? csg_pkg::CMD_FORWARD : csg_pkg::CMD_BACKWARD));
    // zero counts act as one
    configure(0, 0, 0, 1'b1, 1'b1);
    repeat (3) send_item(rand_element(csg_pkg::CMD_BACKWARD));
    // oversized channel count clamps to the table size
    configure(1, 63, 1, 1'b1, 1'b1);
    repeat (csg_pkg::MAX_CHANNELS) send_item(rand_element(csg_pkg::CMD_BACKWARD));
    configure(1, 8, 4, 1'b1, 1'b1);
    repeat (10) send_item(rand_element(csg_pkg::CMD_BACKWARD));
    // shrink counts below the live positions
    configure(1, 2, 1, 1'b1, 1'b1);
    repeat (4) send_item(rand_element(csg_pkg::CMD_BACKWARD));
    configure(COUNT_CAP, csg_pkg::MAX_CHANNELS, COUNT_CAP, 1'b1, 1'b1);
    repeat (3) send_item(rand_element(csg_pkg::CMD_FORWARD));
    repeat (3) send_item(rand_element(csg_pkg::CMD_BACKWARD));
  endtask

  task automatic test_backpressure();
    configure(1, 4, 2, 1'b1, 1'b1);
    gaps_on = 1'b0;
    @(posedge clk);
    ready_hold = HOLD_CYCLES;
    for (int k = 0; k < 24; k++)
      send_item(rand_element((k % 4 == 3) ? csg_pkg::CMD_FORWARD : csg_pkg::CMD_BACKWARD));
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_random();
    int sent;
    int pick;
    int unsigned cc;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: cc = 0;
        1: cc = csg_pkg::MAX_CHANNELS;
        2: cc = 63;
        default: cc = $urandom_range(1, 6);
      endcase
      configure($urandom_range(0, 3), cc, $urandom_range(0, 3),
                $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(10, 30)) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_item(rand_element(csg_pkg::CMD_BACKWARD));
          sent++;
        end else if (pick < 80) begin
          send_item(rand_element(csg_pkg::CMD_FORWARD));
          sent++;
        end else if (pick < 93) begin
          send_item(pack_item(csg_pkg::CMD_LOAD, csg_pkg::IDX_W'($urandom), rand_q12(),
                              csg_pkg::DATA_WIDTH'($urandom),
                              csg_pkg::DATA_WIDTH'($urandom)));
          sent++;
        end else begin
          send_item(rand_element(CMD_UNUSED));
        end
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pass_walk();
    test_backpressure();
    test_random();
    wait_idle();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
